FILE: hw/rtl/mwpo_pkg.sv
// Shared constants, types and sine quarter-wave table for the phase oscillator.
`timescale 1ns / 1ps

package mwpo_pkg;

   // Sine table geometry: one full cycle has TBL_N points, stored as a quarter wave
   localparam int SINE_TABLE_BITS = 10;
   localparam int TBL_N           = 1 << SINE_TABLE_BITS;
   localparam int QTR             = TBL_N / 4;
   localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
   localparam int M_BITS          = SINE_TABLE_BITS - 1;

   // Q31 constants
   localparam logic [31:0] Q31_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] Q31_MIN     = 32'h8000_0000;
   localparam logic [31:0] HALF_Q31    = 32'h4000_0000;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // Item modes
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_ADD  = 2'd1;
   localparam logic [1:0] MODE_LOAD = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_FREQ  = 2'd0;
   localparam logic [1:0] CSR_PULSE = 2'd1;
   localparam logic [1:0] CSR_FB    = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic mult;
      logic addr;
      logic read;
      logic commit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_tick;
   } sts_type;

   // Taylor series divisors (2n)(2n+1) for n = 1..8
   localparam logic [63:0] TAYLOR_DIV [8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   // sin(pi/2 * m / QTR) in Q31, fixed-point Taylor series in Q30
   function automatic logic [31:0] make_quarter(input int unsigned m);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (PI_HALF_Q30 * 64'(m)) / 64'(QTR);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 0; n < 8; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if ((n % 2) == 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      sum = sum * 2;
      if (sum > $signed({32'd0, Q31_MAX})) begin
         sum = $signed({32'd0, Q31_MAX});
      end
      return sum[31:0];
   endfunction

   typedef logic [31:0] quarter_table_type [QTR];

   function automatic quarter_table_type build_quarter_table();
      quarter_table_type t;
      for (int i = 0; i < QTR; i++) begin
         t[i] = make_quarter(i);
      end
      return t;
   endfunction

   // Quarter wave for m = 0 .. QTR-1; the peak at m = QTR stands apart
   localparam quarter_table_type QUARTER_TABLE = build_quarter_table();
   localparam logic [31:0]       SINE_PEAK     = make_quarter(QTR);

endpackage

FILE: hw/rtl/mwpo_ctrl.sv
// Sequencing state machine for the phase oscillator.
`timescale 1ns / 1ps

module mwpo_ctrl import mwpo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MULT = 5'b00010,
      ST_ADDR = 5'b00100,
      ST_READ = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // Output slot free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A new item may enter in the same cycle the previous one commits
      if (accept) begin
         cmd.capture = 1'b1;
         state_in    = sts.is_tick ? ST_MULT : ST_DONE;
      end
   end

   // Result valid flag
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while result slot occupied");

   a_tick_to_mult: assert property (@(posedge clock) disable iff (reset)
      (accept && sts.is_tick) |=> (state_ff == ST_MULT))
      else $error("tick item did not enter multiply step");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MULT) || (state_ff == ST_ADDR) || (state_ff == ST_READ))
      |-> !req_ready)
      else $error("input ready while tick in flight");

   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && $past(!reset)) |-> $past(state_ff == ST_DONE))
      else $error("result valid raised outside commit");
`endif

endmodule

FILE: hw/rtl/mwpo_dp.sv
// Datapath: registers, feedback multiply, phase sum, sine lookup and result registers.
`timescale 1ns / 1ps

module mwpo_dp import mwpo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_phase_value,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic signed [31:0] rsp_sine_out,
   output logic signed [31:0] rsp_pulse_out,
   output logic signed [31:0] rsp_ramp_out,
   output logic signed [31:0] rsp_phase_now
);

   // Configuration registers
   logic [30:0] freq_ff;
   logic [31:0] pw_ff;
   logic [31:0] fb_ff;

   // Oscillator state
   logic [31:0] phase_ff, phase_in;
   logic [31:0] prev_sine_ff;

   // Item and stage registers
   logic [1:0]          mode_ff;
   logic [31:0]         pv_ff;
   logic signed [63:0]  prod_ff;
   logic [31:0]         sum_ff, sum_in;
   logic [31:0]         mag_ff, mag_in;
   logic                neg_ff;
   logic [31:0]         thr_ff, thr_in;

   // Result registers
   logic [31:0] sine_ff, sine_in;
   logic [31:0] pulse_ff, pulse_in;
   logic [31:0] ramp_ff, ramp_in;
   logic [31:0] now_ff;

   logic                       fb_sat;
   logic [31:0]                fb_term;
   logic [32:0]                sum_adj;
   logic [31:0]                u_val;
   logic [SINE_TABLE_BITS-1:0] tbl_index;
   logic [QTR_BITS-1:0]        r_val;
   logic [M_BITS-1:0]          m_val;
   logic [31:0]                inc;
   logic [31:0]                sine_val;

   assign sts.is_tick = (req_mode == MODE_TICK);

   // Register writes; index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= '0;
         pw_ff   <= HALF_Q31;
         fb_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FREQ:  freq_ff <= csr_data[30:0];
            CSR_PULSE: pw_ff   <= csr_data;
            CSR_FB:    fb_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Phase sum: phase plus saturated Q31 product (floor shift), when feedback is on
   assign fb_sat  = !prod_ff[63] && prod_ff[62];
   assign fb_term = fb_sat ? Q31_MAX : prod_ff[62:31];
   assign sum_in  = (fb_ff != '0) ? (phase_ff + fb_term) : phase_ff;

   // Table address: half the phase toward zero, offset by one half
   assign sum_adj   = {sum_ff[31], sum_ff} + {32'd0, sum_ff[31]};
   assign u_val     = sum_adj[32:1] + HALF_Q31;
   assign tbl_index = u_val[30 -: SINE_TABLE_BITS];
   assign r_val     = tbl_index[QTR_BITS-1:0];

   // Quarter-wave folding: odd quadrants run backward
   always_comb begin
      if (tbl_index[SINE_TABLE_BITS-1-1]) begin
         m_val = M_BITS'(QTR) - {1'b0, r_val};
      end else begin
         m_val = {1'b0, r_val};
      end
      if (m_val[M_BITS-1]) begin
         mag_in = SINE_PEAK;
      end else begin
         mag_in = QUARTER_TABLE[m_val[QTR_BITS-1:0]];
      end
   end

   // Pulse threshold: zero for a negative setting
   assign thr_in = pw_ff[31] ? '0 : ((pw_ff - HALF_Q31) << 1);

   // Increment: twice the frequency, saturated
   assign inc = freq_ff[30] ? Q31_MAX : {freq_ff, 1'b0};

   assign sine_val = neg_ff ? (32'd0 - mag_ff) : mag_ff;

   // Result values at commit
   always_comb begin
      sine_in  = '0;
      pulse_in = '0;
      ramp_in  = '0;
      phase_in = phase_ff;
      unique case (mode_ff)
         MODE_TICK: begin
            sine_in  = sine_val;
            pulse_in = ($signed(phase_ff) < $signed(thr_ff)) ? Q31_MAX : Q31_MIN;
            ramp_in  = phase_ff;
            phase_in = phase_ff + inc;
         end
         MODE_ADD: begin
            phase_in = phase_ff + pv_ff;
         end
         MODE_LOAD: begin
            phase_in = pv_ff;
         end
         default: begin
         end
      endcase
   end

   // Oscillator state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= Q31_MIN;
         prev_sine_ff <= '0;
      end else if (cmd.commit) begin
         phase_ff <= phase_in;
         if (mode_ff == MODE_TICK) begin
            prev_sine_ff <= sine_val;
         end
      end
   end

   // Stage and result payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         pv_ff   <= req_phase_value;
      end
      if (cmd.mult) begin
         prod_ff <= $signed(fb_ff) * $signed(prev_sine_ff);
      end
      if (cmd.addr) begin
         sum_ff <= sum_in;
      end
      if (cmd.read) begin
         mag_ff <= mag_in;
         neg_ff <= tbl_index[SINE_TABLE_BITS-1];
         thr_ff <= thr_in;
      end
      if (cmd.commit) begin
         sine_ff  <= sine_in;
         pulse_ff <= pulse_in;
         ramp_ff  <= ramp_in;
         now_ff   <= phase_in;
      end
   end

   assign rsp_sine_out  = sine_ff;
   assign rsp_pulse_out = pulse_ff;
   assign rsp_ramp_out  = ramp_ff;
   assign rsp_phase_now = now_ff;

`ifndef SYNTHESIS
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$past(cmd.commit)) |-> $stable(phase_ff))
      else $error("phase changed without commit");
`endif

endmodule

FILE: hw/rtl/multi_waveform_phase_oscillator.sv
// Top level of the multi-waveform phase oscillator: controller plus datapath.
`timescale 1ns / 1ps
// Tick item: on transfer it steps through multiply, phase sum, table read and commit; a new
// item is taken in the commit cycle, and the commit waits while the result slot is full.
// Phase add and load items go straight to commit, one item per cycle while results are drained.
// Synchronous active-high reset: phase 0x80000000, previous sine 0, frequency 0,
// pulse width 0x40000000, feedback 0. No clearing pass; ready right after reset.

module multi_waveform_phase_oscillator import mwpo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_phase_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sine_out,
   output logic signed [31:0] rsp_pulse_out,
   output logic signed [31:0] rsp_ramp_out,
   output logic signed [31:0] rsp_phase_now,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   cmd_type cmd;
   sts_type sts;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   mwpo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mwpo_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_phase_value (req_phase_value),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_sine_out    (rsp_sine_out),
      .rsp_pulse_out   (rsp_pulse_out),
      .rsp_ramp_out    (rsp_ramp_out),
      .rsp_phase_now   (rsp_phase_now)
   );

endmodule
